### hdl/rbhs_pkg.sv
// Shared types and constants of the radix bin histogram/scan block.
// No dependencies; every other file of the block imports this package.
package rbhs_pkg;

  // default geometry
  localparam int RBHS_TIME_SLOTS = 16;
  localparam int RBHS_BIN_COUNT  = 16;
  localparam int RBHS_GROUPS     = 16;

  // payload widths
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int GRP_W     = 4;
  localparam int BIN_W     = 5;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int SHIFT_W   = 5;
  localparam int MASK_W    = 4;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_CAP  = 2'd2;

  // register reset values
  localparam logic [SHIFT_W-1:0] KEY_SHIFT_RST = 5'd0;
  localparam logic [MASK_W-1:0]  BIN_MASK_RST  = 4'hF;
  localparam logic [DATA_W-1:0]  DEST_CAP_RST  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              overflow;
  } result_t;

endpackage

### hdl/rbhs_if.sv
// Valid/ready channel interfaces for the histogram/scan block.
// Depends on rbhs_pkg for payload widths.
interface rbhs_in_if;
  import rbhs_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] time_slot;
  logic [GRP_W-1:0]  group;
  logic [BIN_W-1:0]  bin_index;
  logic [KEY_W-1:0]  sort_key;

  modport source (output valid, operation, time_slot, group, bin_index, sort_key,
                  input ready);
  modport sink   (input valid, operation, time_slot, group, bin_index, sort_key,
                  output ready);
endinterface

interface rbhs_out_if;
  import rbhs_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              overflow;

  modport source (output valid, result_value, overflow, input ready);
  modport sink   (input valid, result_value, overflow, output ready);
endinterface

### hdl/rbhs_store.sv
// Counter memory: one write port, one registered read port, with
// forwarding of the write made at the same edge as the read. Uses rbhs_pkg.
module rbhs_store #(
  parameter  int DEPTH = rbhs_pkg::RBHS_TIME_SLOTS *
                         (rbhs_pkg::RBHS_BIN_COUNT * rbhs_pkg::RBHS_GROUPS + 1),
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [AW-1:0]             rd_addr,
  output logic [rbhs_pkg::DATA_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rbhs_pkg::DATA_W-1:0] wr_data
);
  import rbhs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;
  logic [AW-1:0]     rd_addr_r;
  logic              fwd_v_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr;
    fwd_addr_r <= wr_addr;
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= wr_en;
    end
  end

  // the array read returns the old word when written at the same edge
  assign rd_data = (fwd_v_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : mem_q_r;

endmodule

### hdl/radix_bin_histogram_scan.sv
// Top level of the radix bin histogram/scan block.
// Depends on rbhs_pkg, rbhs_if (channel interfaces) and rbhs_store.

// Add and read take one beat per cycle while ready is high: each reads its
// word of the counter memory at the beat and, in the s1 stage, writes the
// incremented word back (add) or queues it for the output (read), with the
// write forwarded to a read of the same word made at the same edge. Scan walks
// the whole memory through the single read and write port, one word a cycle,
// and holds the input until its result is queued; clear zeroes one word a
// cycle and holds the input until the whole memory is zeroed. After reset the
// same zeroing pass runs with ready low; configuration writes are taken
// throughout. Two results are held ahead of the output; with two results
// waiting, counting a read still in the s1 stage, ready drops.
module radix_bin_histogram_scan #(
  parameter int TIME_SLOTS = rbhs_pkg::RBHS_TIME_SLOTS,
  parameter int BIN_COUNT  = rbhs_pkg::RBHS_BIN_COUNT,
  parameter int GROUPS     = rbhs_pkg::RBHS_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rbhs_in_if.sink                       in_ch,
  rbhs_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rbhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbhs_pkg::DATA_W-1:0]   cfg_wdata
);
  import rbhs_pkg::*;

  localparam int CELLS = BIN_COUNT * GROUPS;
  localparam int PITCH = CELLS + 1;
  localparam int DEPTH = TIME_SLOTS * PITCH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(PITCH);

  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_TOTAL = CW'(CELLS);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_SCAN  = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAIN = 3'd3;
  localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

  // configuration
  logic [SHIFT_W-1:0] key_shift_r;
  logic [MASK_W-1:0]  bin_mask_r;
  logic [DATA_W-1:0]  dest_cap_r;

  // sequencer
  logic [ST_W-1:0]   state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  logic [DATA_W-1:0] largest_r, largest_nxt;

  // scan data stage
  logic              sc_v_r, sc_v_nxt;
  logic              sc_tot_r, sc_tot_nxt;
  logic [AW-1:0]     sc_addr_r, sc_addr_nxt;

  // add/read stage
  logic              s1_v_r, s1_v_nxt;
  logic              s1_rd_r, s1_rd_nxt;
  logic              s1_zero_r, s1_zero_nxt;
  logic [AW-1:0]     s1_addr_r, s1_addr_nxt;

  // result queue, two deep
  logic              q0_v_r, q0_v_nxt, q1_v_r, q1_v_nxt;
  result_t           q0_r, q0_nxt, q1_r, q1_nxt;
  logic              push, pop;
  result_t           push_data;
  logic [1:0]        held_cnt;

  // memory ports
  logic [AW-1:0]     st_rd_addr, st_wr_addr;
  logic [DATA_W-1:0] st_rd_data, st_wr_data;
  logic              st_wr_en;

  // beat decode
  logic              in_beat;
  logic [MASK_W-1:0] add_bin;
  logic              slot_ok, grp_ok, abin_ok, rd_is_tot, rd_zero;
  logic [AW-1:0]     slot_base, add_addr, rd_addr_calc, acc_addr;

  rbhs_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  always_comb begin
    in_beat   = in_ch.valid && in_ch.ready;
    add_bin   = MASK_W'(in_ch.sort_key >> key_shift_r) & bin_mask_r;
    slot_ok   = 32'(in_ch.time_slot) < 32'(TIME_SLOTS);
    grp_ok    = 32'(in_ch.group) < 32'(GROUPS);
    abin_ok   = 32'(add_bin) < 32'(BIN_COUNT);
    rd_is_tot = 32'(in_ch.bin_index) == 32'(BIN_COUNT);
    rd_zero   = !slot_ok || (32'(in_ch.bin_index) > 32'(BIN_COUNT)) ||
                (!rd_is_tot && !grp_ok);
    slot_base = AW'(in_ch.time_slot) * AW'(PITCH);
    add_addr  = slot_base + AW'(add_bin) * AW'(GROUPS) + AW'(in_ch.group);
    if (rd_is_tot) begin
      rd_addr_calc = slot_base + AW'(CELLS);
    end else begin
      rd_addr_calc = slot_base + AW'(in_ch.bin_index) * AW'(GROUPS) + AW'(in_ch.group);
    end
    acc_addr = (in_ch.operation == OP_READ) ? rd_addr_calc : add_addr;
  end

  always_comb begin
    held_cnt = 2'({1'b0, q0_v_r}) + 2'({1'b0, q1_v_r}) + 2'({1'b0, s1_v_r && s1_rd_r});
    in_ch.ready = (state_r == ST_IDLE) && (held_cnt < 2'd2);
  end

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    largest_nxt = largest_r;
    sc_v_nxt    = 1'b0;
    sc_tot_nxt  = sc_tot_r;
    sc_addr_nxt = sc_addr_r;
    s1_v_nxt    = 1'b0;
    s1_rd_nxt   = s1_rd_r;
    s1_zero_nxt = s1_zero_r;
    s1_addr_nxt = s1_addr_r;
    st_rd_addr  = acc_addr;
    st_wr_en    = 1'b0;
    st_wr_addr  = s1_addr_r;
    st_wr_data  = '0;
    push        = 1'b0;
    push_data   = '0;

    // second half of add / read
    if (s1_v_r) begin
      if (s1_rd_r) begin
        push            = 1'b1;
        push_data.value = s1_zero_r ? '0 : st_rd_data;
      end else begin
        st_wr_en   = 1'b1;
        st_wr_addr = s1_addr_r;
        st_wr_data = st_rd_data + DATA_W'(1);
      end
    end

    // scan: write the running sum back, then fold the old word in
    if (sc_v_r) begin
      st_wr_en   = 1'b1;
      st_wr_addr = sc_addr_r;
      st_wr_data = sum_r;
      if (sc_tot_r) begin
        sum_nxt = '0;
        if (sum_r > largest_r) begin
          largest_nxt = sum_r;
        end
      end else begin
        sum_nxt = sum_r + st_rd_data;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        st_wr_en   = 1'b1;
        st_wr_addr = ptr_r;
        st_wr_data = '0;
        ptr_nxt    = ptr_r + AW'(1);
        if (ptr_r == ADDR_LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          case (in_ch.operation)
            OP_ADD: begin
              s1_v_nxt    = slot_ok && grp_ok && abin_ok;
              s1_rd_nxt   = 1'b0;
              s1_zero_nxt = 1'b0;
              s1_addr_nxt = add_addr;
            end
            OP_READ: begin
              s1_v_nxt    = 1'b1;
              s1_rd_nxt   = 1'b1;
              s1_zero_nxt = rd_zero;
              s1_addr_nxt = rd_addr_calc;
            end
            OP_SCAN: begin
              state_nxt   = ST_SCAN;
              ptr_nxt     = '0;
              cnt_nxt     = '0;
              sum_nxt     = '0;
              largest_nxt = '0;
            end
            default: begin
              state_nxt = ST_CLEAR;
              ptr_nxt   = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        st_rd_addr  = ptr_r;
        sc_v_nxt    = 1'b1;
        sc_addr_nxt = ptr_r;
        sc_tot_nxt  = (cnt_r == CNT_TOTAL);
        cnt_nxt     = (cnt_r == CNT_TOTAL) ? '0 : cnt_r + CW'(1);
        ptr_nxt     = ptr_r + AW'(1);
        if (ptr_r == ADDR_LAST) begin
          ptr_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        push               = 1'b1;
        push_data.value    = largest_r;
        push_data.overflow = largest_r > dest_cap_r;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result queue
  always_comb begin
    pop      = q0_v_r && out_ch.ready;
    q0_v_nxt = q0_v_r;
    q1_v_nxt = q1_v_r;
    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    if (pop && push) begin
      if (q1_v_r) begin
        q0_nxt = q1_r;
        q1_nxt = push_data;
      end else begin
        q0_nxt = push_data;
      end
    end else if (pop) begin
      q0_nxt   = q1_r;
      q0_v_nxt = q1_v_r;
      q1_v_nxt = 1'b0;
    end else if (push) begin
      if (!q0_v_r) begin
        q0_nxt   = push_data;
        q0_v_nxt = 1'b1;
      end else begin
        q1_nxt   = push_data;
        q1_v_nxt = 1'b1;
      end
    end
  end

  assign out_ch.valid        = q0_v_r;
  assign out_ch.result_value = q0_r.value;
  assign out_ch.overflow     = q0_r.overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_shift_r <= KEY_SHIFT_RST;
      bin_mask_r  <= BIN_MASK_RST;
      dest_cap_r  <= DEST_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_SHIFT: key_shift_r <= cfg_wdata[SHIFT_W-1:0];
        CFG_BIN_MASK:  bin_mask_r  <= cfg_wdata[MASK_W-1:0];
        CFG_DEST_CAP:  dest_cap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      cnt_r   <= '0;
      sc_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      q0_v_r  <= 1'b0;
      q1_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      sc_v_r  <= sc_v_nxt;
      s1_v_r  <= s1_v_nxt;
      q0_v_r  <= q0_v_nxt;
      q1_v_r  <= q1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    largest_r <= largest_nxt;
    sc_tot_r  <= sc_tot_nxt;
    sc_addr_r <= sc_addr_nxt;
    s1_rd_r   <= s1_rd_nxt;
    s1_zero_r <= s1_zero_nxt;
    s1_addr_r <= s1_addr_nxt;
    q0_r      <= q0_nxt;
    q1_r      <= q1_nxt;
  end

endmodule

### hdl/rbhs_checker.sv
// Port-level checks for radix_bin_histogram_scan, attached by bind.
// Depends on rbhs_pkg for operation codes and widths.
module rbhs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rbhs_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rbhs_pkg::DATA_W-1:0]   out_result_value,
  input logic                          out_overflow
);
  import rbhs_pkg::*;

  logic       in_beat, out_beat, owes_result;
  logic [2:0] pend_r, pend_nxt;

  assign in_beat     = in_valid && in_ready;
  assign out_beat    = out_valid && out_ready;
  assign owes_result = in_beat && (in_operation == OP_SCAN || in_operation == OP_READ);

  // results owed to the sink: scan and read beats in, result beats out
  always_comb begin
    pend_nxt = pend_r + 3'(owes_result) - 3'(out_beat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // zeroing pass after reset keeps the input closed
  a_clear_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> !in_ready)
    else $error("input open in first cycle after reset");

  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_operation == OP_SCAN || in_operation == OP_CLEAR) |=> !in_ready)
    else $error("input open right after scan or clear beat");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pend_r != 3'd0)
    else $error("result beat without a pending scan or read");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
                                $stable(out_overflow))
    else $error("stalled result changed or dropped");

endmodule

bind radix_bin_histogram_scan rbhs_checker u_rbhs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_operation     (in_ch.operation),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_overflow     (out_ch.overflow)
);
